[rtl/b2d_pkg.sv]
// Shared constants, types and helper functions for the binary to decimal ASCII converter.
package b2d_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam int CONV_WIDTH      = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;
    localparam int BITS_PER_STEP   = 4;
    localparam int STEPS           = (CONV_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int SHIFT_WIDTH     = STEPS * BITS_PER_STEP;
    localparam int STEP_CNT_WIDTH  = $clog2(STEPS + 1);
    localparam int MAX_DIGITS      = 10;
    localparam int DIGIT_WIDTH     = 4;
    localparam int BCD_WIDTH       = MAX_DIGITS * DIGIT_WIDTH;
    localparam int CHAR_WIDTH      = 6;
    localparam int COUNT_WIDTH     = 4;

    localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO   = 6'h30;
    localparam logic [DIGIT_WIDTH-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_WIDTH-1:0] DABBLE_ADD   = 4'd3;

    typedef logic [DIGIT_WIDTH-1:0] bcd_digit_t;
    typedef bcd_digit_t [MAX_DIGITS-1:0] bcd_digits_t;

    typedef struct packed {
        bcd_digits_t             digits;
        logic [COUNT_WIDTH-1:0]  count;
    } bcd_word_t;

    function automatic bcd_digit_t dabble_adjust(input bcd_digit_t d);
        bcd_digit_t r;
        r = (d >= DABBLE_LIMIT) ? (d + DABBLE_ADD) : d;
        return r;
    endfunction

endpackage

[rtl/b2d_if.sv]
// Valid/ready channel interfaces for the binary value input and the ASCII character output.
interface b2d_in_if;
    logic                           valid;
    logic                           ready;
    logic [b2d_pkg::FIELD_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if;
    logic                            valid;
    logic                            ready;
    logic [b2d_pkg::CHAR_WIDTH-1:0]  ascii_char;
    logic                            last;
    logic [b2d_pkg::COUNT_WIDTH-1:0] digit_count;

    modport source (output valid, output ascii_char, output last, output digit_count,
                    input ready);
    modport sink   (input valid, input ascii_char, input last, input digit_count,
                    output ready);
endinterface

[rtl/b2d_dabble.sv]
// Shift-and-add-3 converter that moves four binary bits per cycle into ten BCD digits.
module b2d_dabble
(
    input  logic                  clk,
    input  logic                  rst_n,
    b2d_in_if.sink                value_ch,
    output logic                  word_valid,
    input  logic                  word_ready,
    output b2d_pkg::bcd_word_t    word
);

    logic                                    busy_reg;
    logic                                    busy_next;
    logic [b2d_pkg::STEP_CNT_WIDTH-1:0]      step_reg;
    logic [b2d_pkg::STEP_CNT_WIDTH-1:0]      step_next;
    logic [b2d_pkg::SHIFT_WIDTH-1:0]         bin_reg;
    logic [b2d_pkg::SHIFT_WIDTH-1:0]         bin_next;
    b2d_pkg::bcd_digits_t                    bcd_reg;
    b2d_pkg::bcd_digits_t                    bcd_next;
    logic [b2d_pkg::SHIFT_WIDTH-1:0]         bin_work;
    b2d_pkg::bcd_digits_t                    bcd_work;
    logic [b2d_pkg::BCD_WIDTH-1:0]           bcd_flat;
    logic [b2d_pkg::COUNT_WIDTH-1:0]         digit_total;
    logic                                    done;
    logic                                    take;

    assign done           = busy_reg && (step_reg == '0);
    assign word_valid     = done;
    assign value_ch.ready = !busy_reg || (done && word_ready);
    assign take           = value_ch.valid && value_ch.ready;
    assign word.digits    = bcd_reg;
    assign word.count     = digit_total;

    // Four adjust-and-shift steps of the double dabble per cycle.
    always_comb
    begin
        bin_work = bin_reg;
        bcd_work = bcd_reg;
        bcd_flat = '0;
        for (int b = 0; b < b2d_pkg::BITS_PER_STEP; b++)
        begin
            for (int d = 0; d < b2d_pkg::MAX_DIGITS; d++)
            begin
                bcd_work[d] = b2d_pkg::dabble_adjust(bcd_work[d]);
            end
            bcd_flat = bcd_work;
            bcd_flat = {bcd_flat[b2d_pkg::BCD_WIDTH-2:0], bin_work[b2d_pkg::SHIFT_WIDTH-1]};
            bcd_work = bcd_flat;
            bin_work = bin_work << 1;
        end
    end

    // The run length is the position of the highest nonzero digit, and at least one.
    always_comb
    begin
        digit_total = b2d_pkg::COUNT_WIDTH'(1);
        for (int d = 0; d < b2d_pkg::MAX_DIGITS; d++)
        begin
            if (bcd_reg[d] != '0)
            begin
                digit_total = b2d_pkg::COUNT_WIDTH'(d + 1);
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (done && word_ready)
        begin
            busy_next = 1'b0;
        end
        if (busy_reg && (step_reg != '0))
        begin
            step_next = step_reg - b2d_pkg::STEP_CNT_WIDTH'(1);
            bin_next  = bin_work;
            bcd_next  = bcd_work;
        end
        if (take)
        begin
            busy_next = 1'b1;
            step_next = b2d_pkg::STEP_CNT_WIDTH'(b2d_pkg::STEPS);
            bin_next  = b2d_pkg::SHIFT_WIDTH'(value_ch.value[b2d_pkg::CONV_WIDTH-1:0]);
            bcd_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

[rtl/b2d_emit.sv]
// Digit emitter that sends the stored BCD digits as ASCII characters, most significant first.
module b2d_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    output logic                  word_ready,
    input  b2d_pkg::bcd_word_t    word,
    b2d_out_if.source             char_ch
);

    b2d_pkg::bcd_digits_t                digits_reg;
    b2d_pkg::bcd_digits_t                digits_next;
    logic [b2d_pkg::COUNT_WIDTH-1:0]     remain_reg;
    logic [b2d_pkg::COUNT_WIDTH-1:0]     remain_next;
    logic [b2d_pkg::COUNT_WIDTH-1:0]     count_reg;
    logic [b2d_pkg::COUNT_WIDTH-1:0]     count_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [b2d_pkg::CHAR_WIDTH-1:0]      char_reg;
    logic [b2d_pkg::CHAR_WIDTH-1:0]      char_next;
    logic                                last_reg;
    logic                                last_next;
    logic [b2d_pkg::COUNT_WIDTH-1:0]     out_count_reg;
    logic [b2d_pkg::COUNT_WIDTH-1:0]     out_count_next;
    logic [b2d_pkg::COUNT_WIDTH-1:0]     sel_idx;
    b2d_pkg::bcd_digit_t                 sel_digit;
    logic                                load_out;

    assign word_ready          = (remain_reg == '0);
    assign load_out            = (remain_reg != '0) && (!out_valid_reg || char_ch.ready);
    assign sel_idx             = remain_reg - b2d_pkg::COUNT_WIDTH'(1);
    assign sel_digit           = digits_reg[sel_idx];

    assign char_ch.valid       = out_valid_reg;
    assign char_ch.ascii_char  = char_reg;
    assign char_ch.last        = last_reg;
    assign char_ch.digit_count = out_count_reg;

    always_comb
    begin
        digits_next    = digits_reg;
        remain_next    = remain_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_count_next = out_count_reg;
        if (char_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            char_next      = b2d_pkg::ASCII_ZERO + b2d_pkg::CHAR_WIDTH'(sel_digit);
            last_next      = (remain_reg == b2d_pkg::COUNT_WIDTH'(1));
            out_count_next = count_reg;
            remain_next    = sel_idx;
        end
        if (word_valid && word_ready)
        begin
            digits_next = word.digits;
            count_next  = word.count;
            remain_next = word.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg    <= digits_next;
        count_reg     <= count_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
        out_count_reg <= out_count_next;
    end

endmodule

[rtl/binary_to_decimal_ascii_core.sv]
// Top level of the binary to decimal ASCII converter.
// The value channel takes one unsigned 32-bit value per transfer. The char channel
// returns its decimal digits as ASCII characters, most significant first, with
// leading zeros suppressed; zero gives the single character '0'. Each character
// carries last on the least significant digit and the run's digit count.
// A value is converted by a shift-and-add-3 unit that takes four bits per cycle.
// The digits then pass the emitter's digit register and its output register, and
// the characters follow one per cycle while the receiver is ready.
// The emitter holds one finished run while the converter works on the next
// value; the converter can take a new value in the same cycle as it hands its run
// to the emitter, once the emitter has loaded every character of the last run.
// When the receiver stalls, the output register holds its character, the emitter
// waits, and the value channel keeps ready low while a finished run is held.
// Reset clears all handshake state; no transfer is pending after reset.
module binary_to_decimal_ascii_core
(
    input  logic        clk,
    input  logic        rst_n,
    b2d_in_if.sink      value_ch,
    b2d_out_if.source   char_ch
);

    logic                  word_valid;
    logic                  word_ready;
    b2d_pkg::bcd_word_t    word;

    b2d_dabble u_dabble
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_ch   (value_ch),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word)
    );

    b2d_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word),
        .char_ch    (char_ch)
    );

endmodule

[rtl/b2d_checker.sv]
// Port-level assertions for the binary to decimal ASCII converter and their binding.
module b2d_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            char_valid,
    input  logic                            char_ready,
    input  logic [b2d_pkg::CHAR_WIDTH-1:0]  ascii_char,
    input  logic                            last,
    input  logic [b2d_pkg::COUNT_WIDTH-1:0] digit_count
);

    // A stalled character stays in place until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(ascii_char) && $stable(last)
            && $stable(digit_count))
        else $error("stalled character changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (ascii_char[5:4] == 2'b11) && (ascii_char[3:0] <= 4'd9))
        else $error("character is not a decimal digit");

    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (digit_count >= 4'd1) && (digit_count <= 4'd10))
        else $error("digit count out of range");

    // A one-digit run consists of its last character alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && (digit_count == 4'd1) |-> last)
        else $error("single-digit run without last");

endmodule

bind binary_to_decimal_ascii_core b2d_checker u_b2d_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .char_valid  (char_ch.valid),
    .char_ready  (char_ch.ready),
    .ascii_char  (char_ch.ascii_char),
    .last        (char_ch.last),
    .digit_count (char_ch.digit_count)
);
